// ===== design/sbrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared types and constants of the binding response parser.
// ----------------------------------------------------------------------------
package sbrp_pkg;

  localparam int HDR_LEN     = 20;
  localparam int VALUE_DEPTH = 20;
  localparam int POS_W       = 17;

  localparam logic [POS_W-1:0] POS_MAX      = '1;
  localparam logic [15:0]      MSG_BINDING_RESP = 16'h0101;
  localparam logic [31:0]      MAGIC_COOKIE = 32'h2112A442;
  localparam logic [15:0]      KIND_XOR     = 16'h0020;
  localparam logic [15:0]      KIND_PLAIN   = 16'h0001;
  localparam logic [7:0]       FAM_V4       = 8'h01;
  localparam logic [7:0]       FAM_V6       = 8'h02;

  typedef logic [2:0] sbrp_status_t;
  localparam sbrp_status_t ST_FOUND  = 3'd0;
  localparam sbrp_status_t ST_SHORT  = 3'd1;
  localparam sbrp_status_t ST_TRUNC  = 3'd2;
  localparam sbrp_status_t ST_TYPE   = 3'd3;
  localparam sbrp_status_t ST_COOKIE = 3'd4;
  localparam sbrp_status_t ST_TID    = 3'd5;
  localparam sbrp_status_t ST_NOADDR = 3'd6;

  typedef logic [1:0] sbrp_reg_idx_t;
  localparam sbrp_reg_idx_t REG_TID_HIGH = 2'd0;
  localparam sbrp_reg_idx_t REG_TID_LOW  = 2'd1;

  typedef struct packed {
    logic        valid;
    logic        last_byte;
    logic [7:0]  rx_byte;
  } sbrp_item_t;

  typedef struct packed {
    logic [31:0] high;
    logic [63:0] low;
  } sbrp_tid_t;

  function automatic logic [7:0] type_byte(input logic idx);
    return idx ? MSG_BINDING_RESP[7:0] : MSG_BINDING_RESP[15:8];
  endfunction

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] res;
    case (idx)
      2'd0:    res = MAGIC_COOKIE[31:24];
      2'd1:    res = MAGIC_COOKIE[23:16];
      2'd2:    res = MAGIC_COOKIE[15:8];
      default: res = MAGIC_COOKIE[7:0];
    endcase
    return res;
  endfunction

endpackage

// ===== design/sbrp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrp_in_if
// Datagram byte channel: one byte and a last flag per transaction.
// ----------------------------------------------------------------------------
interface sbrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// ===== design/sbrp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrp_out_if
// Parse result channel: one status transaction per datagram.
// ----------------------------------------------------------------------------
interface sbrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        from_xor_attribute;
  logic        is_ipv6;
  logic [15:0] mapped_port;
  logic [63:0] addr_upper;
  logic [63:0] addr_lower;

  modport source (output valid, output status, output from_xor_attribute,
                  output is_ipv6, output mapped_port, output addr_upper,
                  output addr_lower, input ready);
  modport sink   (input valid, input status, input from_xor_attribute,
                  input is_ipv6, input mapped_port, input addr_upper,
                  input addr_lower, output ready);
endinterface

// ===== design/sbrp_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrp_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sbrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/stun_binding_response_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_binding_response_parser
// Checks a STUN binding success response byte by byte and returns the
// mapped address with a status code on the datagram's last byte.
// ----------------------------------------------------------------------------
//  channel    dir  transaction                      payload
//  in_chan    in   one datagram byte                rx_byte, last_byte
//  out_chan   out  one status per datagram          status, flags, port, address
//  cfg_chan   in   register write                   reg_index, wdata
//
//  one byte per cycle sustained while no last byte waits on a pending result;
//  a byte is held in the input register; the last byte's result is registered
//  all work per byte is compares, xor and counter updates in the core stage
//  a pending result stalls only the next last byte, not ordinary bytes
//  synchronous active-low reset clears the parser state and the id registers
// ----------------------------------------------------------------------------
module stun_binding_response_parser (
  input  logic      clk,
  input  logic      rst_n,
  sbrp_in_if.sink   in_chan,
  sbrp_out_if.source out_chan,
  sbrp_cfg_if.sink  cfg_chan
);
  import sbrp_pkg::*;

  sbrp_tid_t  tid;
  sbrp_item_t item;
  logic       take;

  sbrp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .tid      (tid)
  );

  sbrp_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .item    (item)
  );

  sbrp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .tid      (tid),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule

// ===== design/sbrp_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrp_cfg_regs
// Expected transaction id registers, written over the config channel.
// ----------------------------------------------------------------------------
module sbrp_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  sbrp_cfg_if.sink          cfg_chan,
  output sbrp_pkg::sbrp_tid_t tid
);
  import sbrp_pkg::*;

  logic [31:0] tid_high_r;
  logic [63:0] tid_low_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tid_high_r <= '0;
      tid_low_r  <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        REG_TID_HIGH: tid_high_r <= cfg_chan.wdata[31:0];
        REG_TID_LOW:  tid_low_r  <= cfg_chan.wdata;
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  assign tid.high = tid_high_r;
  assign tid.low  = tid_low_r;

endmodule

// ===== design/sbrp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrp_in_stage
// Input register for datagram bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module sbrp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  sbrp_in_if.sink            in_chan,
  input  logic               take,
  output sbrp_pkg::sbrp_item_t item
);
  import sbrp_pkg::*;

  logic       valid_r;
  logic       last_r;
  logic [7:0] byte_r;
  logic       accept;

  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_chan.last_byte;
      byte_r <= in_chan.rx_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.last_byte = last_r;
  assign item.rx_byte   = byte_r;

endmodule

// ===== design/sbrp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrp_core
// Header check, attribute walk, address decode and the result register.
// ----------------------------------------------------------------------------
module sbrp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sbrp_pkg::sbrp_item_t item,
  input  sbrp_pkg::sbrp_tid_t  tid,
  output logic                 take,
  sbrp_out_if.source           out_chan
);
  import sbrp_pkg::*;

  // per-datagram state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      dlen_r, dlen_nxt;
  sbrp_status_t     hs_r, hs_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [15:0]      kind_r, kind_nxt;
  logic [15:0]      alen_r, alen_nxt;
  logic             found_r, found_nxt;
  logic [15:0]      fport_r, fport_nxt;
  logic [63:0]      fhi_r, fhi_nxt;
  logic [63:0]      flo_r, flo_nxt;
  logic [1:0]       fflags_r, fflags_nxt;
  logic             ended_r, ended_nxt;
  logic [7:0]       vb_r [VALUE_DEPTH];

  // result register
  logic             ovalid_r;
  sbrp_status_t     status_r, status_nxt;
  logic             oxor_r;
  logic             ov6_r;
  logic [15:0]      oport_r;
  logic [63:0]      oup_r;
  logic [63:0]      olo_r;

  logic [7:0]       b;
  logic [POS_W-1:0] end_pos;
  logic             walk_on;
  logic [POS_W-1:0] k;
  logic [POS_W-1:0] kv;
  logic [4:0]       vidx;
  logic             in_attr_hdr;
  logic             store_hit;
  logic             val_end;
  logic [15:0]      len_new;
  logic [POS_W:0]   hdr_lim;
  logic [POS_W-1:0] pad_len;
  logic [POS_W:0]   next_start;
  logic [7:0]       vbm [VALUE_DEPTH];
  logic [7:0]       tid_b [12];
  logic [4:0]       hp;
  logic [3:0]       tidx;
  sbrp_status_t     hdr_err;

  // address decode
  logic             is_xor;
  logic             eval_ok;
  logic [15:0]      eval_port;
  logic [63:0]      eval_hi;
  logic [63:0]      eval_lo;
  logic             eval_v6;

  assign b    = item.rx_byte;
  assign take = item.valid && (!item.last_byte || !ovalid_r || out_chan.ready);

  assign end_pos     = POS_W'(HDR_LEN) + {1'b0, dlen_r};
  assign walk_on     = (pos_r >= POS_W'(HDR_LEN)) && !found_r && !ended_r &&
                       (pos_r >= start_r) && (pos_r < end_pos);
  assign k           = pos_r - start_r;
  assign in_attr_hdr = k < POS_W'(4);
  assign kv          = k - POS_W'(4);
  assign vidx        = kv[4:0];
  assign store_hit   = walk_on && !in_attr_hdr && (kv < POS_W'(VALUE_DEPTH));
  assign val_end     = walk_on && !in_attr_hdr &&
                       ({1'b0, kv} + (POS_W+1)'(1) == (POS_W+1)'(alen_r));
  assign len_new     = {alen_r[15:8], b};
  assign hdr_lim     = {1'b0, start_r} + (POS_W+1)'(4) + (POS_W+1)'(len_new);
  assign pad_len     = (POS_W'(alen_r) + POS_W'(3)) & ~POS_W'(3);
  assign next_start  = {1'b0, start_r} + (POS_W+1)'(4) + {1'b0, pad_len};

  assign hp   = pos_r[4:0];
  assign tidx = 4'(hp - 5'd8);

  // value bytes as seen with the current byte already stored
  always_comb begin
    for (int i = 0; i < VALUE_DEPTH; i++) begin
      vbm[i] = (store_hit && vidx == 5'(i)) ? b : vb_r[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tid_b[i] = tid.high[8*(3-i) +: 8];
    end
    for (int i = 4; i < 12; i++) begin
      tid_b[i] = tid.low[8*(11-i) +: 8];
    end
  end

  always_comb begin
    is_xor    = kind_r == KIND_XOR;
    eval_v6   = vbm[1] == FAM_V6;
    eval_port = {vbm[2], vbm[3]} ^ (is_xor ? MAGIC_COOKIE[31:16] : 16'h0000);
    eval_ok   = (is_xor || kind_r == KIND_PLAIN) && (alen_r >= 16'd4) &&
                (vbm[0] == 8'h00) &&
                ((vbm[1] == FAM_V4 && alen_r >= 16'd8) ||
                 (eval_v6 && alen_r >= 16'd20));
    if (eval_v6) begin
      eval_hi = {vbm[4], vbm[5], vbm[6], vbm[7], vbm[8], vbm[9], vbm[10], vbm[11]} ^
                (is_xor ? {MAGIC_COOKIE, tid.high} : 64'h0);
      eval_lo = {vbm[12], vbm[13], vbm[14], vbm[15], vbm[16], vbm[17], vbm[18],
                 vbm[19]} ^ (is_xor ? tid.low : 64'h0);
    end else begin
      eval_hi = 64'h0;
      eval_lo = {32'h0, {vbm[4], vbm[5], vbm[6], vbm[7]} ^
                        (is_xor ? MAGIC_COOKIE : 32'h0)};
    end
  end

  always_comb begin
    dlen_nxt   = dlen_r;
    hs_nxt     = hs_r;
    start_nxt  = start_r;
    kind_nxt   = kind_r;
    alen_nxt   = alen_r;
    found_nxt  = found_r;
    fport_nxt  = fport_r;
    fhi_nxt    = fhi_r;
    flo_nxt    = flo_r;
    fflags_nxt = fflags_r;
    ended_nxt  = ended_r;
    hdr_err    = ST_FOUND;

    if (pos_r < POS_W'(HDR_LEN)) begin
      if (hp inside {[5'd0:5'd1]}) begin
        if (b != type_byte(hp[0])) hdr_err = ST_TYPE;
      end else if (hp inside {[5'd2:5'd3]}) begin
        dlen_nxt = {dlen_r[7:0], b};
      end else if (hp inside {[5'd4:5'd7]}) begin
        if (b != cookie_byte(hp[1:0])) hdr_err = ST_COOKIE;
      end else begin
        if (b != tid_b[tidx]) hdr_err = ST_TID;
      end
      if (hdr_err != ST_FOUND && hs_r == ST_FOUND) hs_nxt = hdr_err;
    end else if (walk_on) begin
      if (in_attr_hdr) begin
        case (k[1:0])
          2'd0: kind_nxt = {b, 8'h00};
          2'd1: kind_nxt = {kind_r[15:8], b};
          2'd2: alen_nxt = {b, 8'h00};
          default: begin
            alen_nxt = len_new;
            // value would run past the declared end
            if (hdr_lim > (POS_W+1)'(end_pos)) begin
              ended_nxt = 1'b1;
            end else if (len_new == 16'd0) begin
              start_nxt = start_r + POS_W'(4);
            end
          end
        endcase
      end else if (val_end) begin
        if (eval_ok) begin
          found_nxt  = 1'b1;
          fport_nxt  = eval_port;
          fhi_nxt    = eval_hi;
          flo_nxt    = eval_lo;
          fflags_nxt = {eval_v6, is_xor};
        end
        start_nxt = next_start[POS_W-1:0];
      end
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);

    if (pos_nxt < POS_W'(HDR_LEN)) begin
      status_nxt = ST_SHORT;
    end else if (pos_nxt < POS_W'(HDR_LEN) + {1'b0, dlen_nxt}) begin
      status_nxt = ST_TRUNC;
    end else if (hs_nxt != ST_FOUND) begin
      status_nxt = hs_nxt;
    end else if (found_nxt) begin
      status_nxt = ST_FOUND;
    end else begin
      status_nxt = ST_NOADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && item.last_byte)) begin
      pos_r    <= '0;
      dlen_r   <= '0;
      hs_r     <= ST_FOUND;
      start_r  <= POS_W'(HDR_LEN);
      kind_r   <= '0;
      alen_r   <= '0;
      found_r  <= 1'b0;
      fport_r  <= '0;
      fhi_r    <= '0;
      flo_r    <= '0;
      fflags_r <= '0;
      ended_r  <= 1'b0;
    end else if (take) begin
      pos_r    <= pos_nxt;
      dlen_r   <= dlen_nxt;
      hs_r     <= hs_nxt;
      start_r  <= start_nxt;
      kind_r   <= kind_nxt;
      alen_r   <= alen_nxt;
      found_r  <= found_nxt;
      fport_r  <= fport_nxt;
      fhi_r    <= fhi_nxt;
      flo_r    <= flo_nxt;
      fflags_r <= fflags_nxt;
      ended_r  <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && store_hit) begin
      vb_r[vidx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (take && item.last_byte) begin
      ovalid_r <= 1'b1;
    end else if (out_chan.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_byte) begin
      status_r <= status_nxt;
      if (status_nxt == ST_FOUND) begin
        oxor_r  <= fflags_nxt[0];
        ov6_r   <= fflags_nxt[1];
        oport_r <= fport_nxt;
        oup_r   <= fhi_nxt;
        olo_r   <= flo_nxt;
      end else begin
        oxor_r  <= 1'b0;
        ov6_r   <= 1'b0;
        oport_r <= '0;
        oup_r   <= '0;
        olo_r   <= '0;
      end
    end
  end

  assign out_chan.valid              = ovalid_r;
  assign out_chan.status             = status_r;
  assign out_chan.from_xor_attribute = oxor_r;
  assign out_chan.is_ipv6            = ov6_r;
  assign out_chan.mapped_port        = oport_r;
  assign out_chan.addr_upper         = oup_r;
  assign out_chan.addr_lower         = olo_r;

  a_fail_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && status_r != ST_FOUND) |->
      (oup_r == 64'h0 && olo_r == 64'h0 && oport_r == 16'h0 && !oxor_r && !ov6_r))
    else $error("failing status carries a nonzero payload");

  a_v4_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !ov6_r) |-> (oup_r == 64'h0))
    else $error("ipv4 result with nonzero upper address");

  a_start_floor: assert property (@(posedge clk) disable iff (!rst_n)
    start_r >= POS_W'(HDR_LEN))
    else $error("attribute start below header length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.last_byte) |=> (pos_r == '0 && !found_r && ovalid_r))
    else $error("datagram state not cleared after last byte");

endmodule
